@@ sv/sorted_interval_reservation_table_assert.svh @@
// assertion macros used by the interval table controller
`ifndef SORTED_INTERVAL_RESERVATION_TABLE_ASSERT_SVH
`define SORTED_INTERVAL_RESERVATION_TABLE_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SIRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SIRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sirt_pkg.sv @@
// types and constants of the sorted interval reservation table
package sirt_pkg;

    localparam int CMD_W    = 2;
    localparam int TIME_W   = 11;
    localparam int ROOM_W   = 16;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    localparam int DEFAULT_CAPACITY = 64;

    // 24 hours with 6 fraction bits
    localparam logic [TIME_W-1:0] DAY_END = 11'd1536;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_INVALID = 3'd1,
        STS_OVERLAP = 3'd2,
        STS_FULL    = 3'd3,
        STS_MISSING = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0] slot_start;
        logic [TIME_W-1:0] slot_end;
        logic [ROOM_W-1:0] room;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ sv/sirt_mem.sv @@
// single-port-write, single-port-read entry memory with registered read data
module sirt_mem
    import sirt_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/sirt_ctrl.sv @@
// sequencer: scan, shift and place over the entry memory, plus the result register
`include "sorted_interval_reservation_table_assert.svh"

module sirt_ctrl
    import sirt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY,
    parameter int AW       = $clog2(CAPACITY),
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item channel
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [TIME_W-1:0]   i_start_time,
    input  logic [TIME_W-1:0]   i_end_time,
    input  logic [ROOM_W-1:0]   i_room,
    // result channel
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [TIME_W-1:0]   o_found_start,
    output logic [TIME_W-1:0]   o_found_end,
    output logic [ROOM_W-1:0]   o_found_room,
    output logic [TOTAL_W-1:0]  o_entry_total,
    // memory port
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr,
    input  t_entry              i_rd_data,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output t_entry              o_wr_data
);

    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [AW-1:0] STEP_A = AW'(1);

    t_state  r_state, n_state;
    t_cmd    r_cmd, n_cmd;
    t_entry  r_item, n_item;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_chk, n_chk;
    logic [CW-1:0] r_chk_idx, n_chk_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic          r_pos_set, n_pos_set;
    logic [AW-1:0] r_src, n_src;
    logic [CW-1:0] r_left, n_left;
    logic          r_wpend, n_wpend;
    logic [AW-1:0] r_wdst, n_wdst;
    t_status r_res_status, n_res_status;
    t_entry  r_res_entry, n_res_entry;
    logic          r_ovalid, n_ovalid;
    t_status r_out_status, n_out_status;
    t_entry  r_out_entry, n_out_entry;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;

    logic accept;
    logic in_bad;
    logic is_insert;
    logic chk_overlap;
    logic chk_match;
    logic scan_end;
    logic shift_end;
    logic out_free;
    logic [CW-1:0] next_after_hit;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign in_bad    = (i_start_time >= i_end_time) || (i_end_time > DAY_END);
    assign is_insert = (r_cmd == CMD_INSERT);
    // half-open intersection against the entry read last cycle
    assign chk_overlap = r_chk && is_insert && (r_item.slot_start < i_rd_data.slot_end)
                         && (r_item.slot_end > i_rd_data.slot_start);
    assign chk_match = r_chk && !is_insert && (i_rd_data.slot_start == r_item.slot_start);
    assign scan_end  = !r_chk && (r_idx >= r_count);
    assign shift_end = (r_left == '0) && !r_wpend;
    assign out_free  = !r_ovalid || i_ready;
    assign next_after_hit = r_chk_idx + ONE_C;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((t_cmd'(i_cmd) == CMD_NONE)
                        || ((t_cmd'(i_cmd) == CMD_INSERT) && in_bad)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                priority if (chk_overlap) begin
                    n_state = ST_DONE;
                end else if (chk_match) begin
                    n_state = (r_cmd == CMD_FIND) ? ST_DONE : ST_SHIFT;
                end else if (scan_end) begin
                    n_state = (is_insert && (r_count < CAP_C)) ? ST_SHIFT : ST_DONE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SHIFT: begin
                if (shift_end) begin
                    n_state = is_insert ? ST_PLACE : ST_DONE;
                end
            end
            ST_PLACE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory control and datapath
    always_comb begin
        n_cmd        = r_cmd;
        n_item       = r_item;
        n_count      = r_count;
        n_idx        = r_idx;
        n_chk        = r_chk;
        n_chk_idx    = r_chk_idx;
        n_pos        = r_pos;
        n_pos_set    = r_pos_set;
        n_src        = r_src;
        n_left       = r_left;
        n_wpend      = r_wpend;
        n_wdst       = r_wdst;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_ovalid     = r_ovalid && !i_ready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_total  = r_out_total;
        o_rd_en      = 1'b0;
        o_rd_addr    = '0;
        o_wr_en      = 1'b0;
        o_wr_addr    = '0;
        o_wr_data    = i_rd_data;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd              = t_cmd'(i_cmd);
                    n_item.slot_start  = i_start_time;
                    n_item.slot_end    = i_end_time;
                    n_item.room        = i_room;
                    n_res_entry        = '0;
                    n_res_status       = STS_OK;
                    n_idx              = '0;
                    n_chk              = 1'b0;
                    n_pos              = r_count;
                    n_pos_set          = 1'b0;
                    n_wpend            = 1'b0;
                    n_left             = '0;
                    if ((t_cmd'(i_cmd) == CMD_NONE)
                        || ((t_cmd'(i_cmd) == CMD_INSERT) && in_bad)) begin
                        n_res_status = STS_INVALID;
                    end
                end
            end
            ST_SCAN: begin
                // one read issued per cycle, checked the cycle after
                o_rd_en   = (r_idx < r_count);
                o_rd_addr = r_idx[AW-1:0];
                n_chk     = o_rd_en;
                n_chk_idx = r_idx;
                if (o_rd_en) begin
                    n_idx = r_idx + ONE_C;
                end
                // first stored start not below the new one is the insert slot
                if (r_chk && is_insert && !r_pos_set
                    && (i_rd_data.slot_start >= r_item.slot_start)) begin
                    n_pos     = r_chk_idx;
                    n_pos_set = 1'b1;
                end
                priority if (chk_overlap) begin
                    n_res_status = STS_OVERLAP;
                end else if (chk_match) begin
                    if (r_cmd == CMD_FIND) begin
                        n_res_entry = i_rd_data;
                    end else begin
                        n_src   = next_after_hit[AW-1:0];
                        n_left  = r_count - next_after_hit;
                        n_wpend = 1'b0;
                    end
                end else if (scan_end) begin
                    if (!is_insert) begin
                        n_res_status = STS_MISSING;
                    end else if (r_count >= CAP_C) begin
                        n_res_status = STS_FULL;
                    end else begin
                        n_src   = AW'(r_count - ONE_C);
                        n_left  = r_count - r_pos;
                        n_wpend = 1'b0;
                    end
                end else begin
                    n_res_status = r_res_status;
                end
            end
            ST_SHIFT: begin
                // read one slot ahead, write it to its neighbor next cycle
                o_rd_en   = (r_left != '0);
                o_rd_addr = r_src;
                o_wr_en   = r_wpend;
                o_wr_addr = r_wdst;
                o_wr_data = i_rd_data;
                n_wpend   = o_rd_en;
                if (o_rd_en) begin
                    n_left = r_left - ONE_C;
                    n_src  = is_insert ? (r_src - STEP_A) : (r_src + STEP_A);
                    n_wdst = is_insert ? (r_src + STEP_A) : (r_src - STEP_A);
                end
                if (shift_end && !is_insert) begin
                    n_count      = r_count - ONE_C;
                    n_res_status = STS_OK;
                end
            end
            ST_PLACE: begin
                o_wr_en      = 1'b1;
                o_wr_addr    = r_pos[AW-1:0];
                o_wr_data    = r_item;
                n_count      = r_count + ONE_C;
                n_res_status = STS_OK;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid     = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_total  = TOTAL_W'(r_count);
                end
            end
            default: begin
                n_ovalid = r_ovalid && !i_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_chk    <= 1'b0;
            r_wpend  <= 1'b0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_chk    <= n_chk;
            r_wpend  <= n_wpend;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_item       <= n_item;
        r_idx        <= n_idx;
        r_chk_idx    <= n_chk_idx;
        r_pos        <= n_pos;
        r_pos_set    <= n_pos_set;
        r_src        <= n_src;
        r_wdst       <= n_wdst;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_total  <= n_out_total;
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_status      = r_out_status;
    assign o_found_start = r_out_entry.slot_start;
    assign o_found_end   = r_out_entry.slot_end;
    assign o_found_room  = r_out_entry.room;
    assign o_entry_total = r_out_total;

    `SIRT_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CAP_C, "entry count above capacity")
    `SIRT_ASSERT_IMP(a_rw_distinct, o_rd_en && o_wr_en, o_rd_addr != o_wr_addr,
        "read and write hit the same slot")
    `SIRT_ASSERT_NXT(a_place_grows, r_state == ST_PLACE, r_count == $past(r_count) + ONE_C,
        "placement did not grow the table")
    `SIRT_ASSERT_NXT(a_idle_count, r_state == ST_IDLE || r_state == ST_DONE, $stable(r_count),
        "entry count moved outside an operation")

endmodule

@@ sv/sorted_interval_reservation_table.sv @@
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// item in  | i_valid / o_ready  | i_cmd, i_start_time, i_end_time, i_room
// result   | o_valid / i_ready  | o_status, o_found_start/end/room, o_entry_total
//
// one item at a time; from input transfer to result: find or miss scans with one read per
// entry, then drains the read pipe and loads the result; insert runs the overlap scan, one
// read and one write per moved entry and a placing write; remove scans to its hit and then
// moves the entries after it; invalid inserts and the unused command go straight to result.
// reset empties the table at once by clearing the entry count; the memory is not swept.
// the result sits in an output register, so the next item is taken while it waits.
module sorted_interval_reservation_table
    import sirt_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [CMD_W-1:0]    i_cmd,
    input  logic [TIME_W-1:0]   i_start_time,
    input  logic [TIME_W-1:0]   i_end_time,
    input  logic [ROOM_W-1:0]   i_room,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [TIME_W-1:0]   o_found_start,
    output logic [TIME_W-1:0]   o_found_end,
    output logic [ROOM_W-1:0]   o_found_room,
    output logic [TOTAL_W-1:0]  o_entry_total
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;

    sirt_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_start_time  (i_start_time),
        .i_end_time    (i_end_time),
        .i_room        (i_room),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_start (o_found_start),
        .o_found_end   (o_found_end),
        .o_found_room  (o_found_room),
        .o_entry_total (o_entry_total),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    sirt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

endmodule

@@ test/sorted_interval_reservation_table_tb.sv @@
// self-checking testbench for the sorted interval reservation table
`timescale 1ns / 100ps

module sorted_interval_reservation_table_tb;
    import sirt_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_CAPACITY;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PRINT_LIMIT = 40;
    localparam int SLOT_PITCH = 24;

    typedef struct {
        t_cmd              cmd;
        logic [TIME_W-1:0] slot_start;
        logic [TIME_W-1:0] slot_end;
        logic [ROOM_W-1:0] room;
        bit                drain_before;
    } t_booking_req;

    typedef struct {
        t_status            status;
        logic [TIME_W-1:0]  found_start;
        logic [TIME_W-1:0]  found_end;
        logic [ROOM_W-1:0]  found_room;
        logic [TOTAL_W-1:0] entry_total;
    } t_booking_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [CMD_W-1:0]    i_cmd = CMD_NONE;
    logic [TIME_W-1:0]   i_start_time = '0;
    logic [TIME_W-1:0]   i_end_time = '0;
    logic [ROOM_W-1:0]   i_room = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [TIME_W-1:0]   o_found_start;
    logic [TIME_W-1:0]   o_found_end;
    logic [ROOM_W-1:0]   o_found_room;
    logic [TOTAL_W-1:0]  o_entry_total;

    sorted_interval_reservation_table #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_start_time  (i_start_time),
        .i_end_time    (i_end_time),
        .i_room        (i_room),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_start (o_found_start),
        .o_found_end   (o_found_end),
        .o_found_room  (o_found_room),
        .o_entry_total (o_entry_total)
    );

    // shadow copy of the interval table
    logic [TIME_W-1:0] tbl_start [TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_end   [TABLE_DEPTH];
    logic [ROOM_W-1:0] tbl_room  [TABLE_DEPTH];
    int                tbl_count = 0;
    int                peak_count = 0;

    t_booking_req      pending_bookings [$];
    t_booking_reply    booking_replies [$];
    logic [TIME_W-1:0] key_pool [$];

    int items_taken = 0;
    int results_seen = 0;
    int error_count = 0;
    int cycle_count = 0;
    int status_tally [5];

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("error at cycle %0d, result %0d: %s", cycle_count, results_seen, msg);
        error_count++;
    endtask

    function automatic int locate_start(input logic [TIME_W-1:0] key);
        int idx;
        for (idx = 0; idx < tbl_count; idx++) begin
            if (tbl_start[idx] == key)
                return idx;
        end
        return -1;
    endfunction

    task automatic apply_booking(input t_cmd cmd, input logic [TIME_W-1:0] s,
                                 input logic [TIME_W-1:0] e, input logic [ROOM_W-1:0] r,
                                 output t_booking_reply rep);
        int  idx;
        int  pos;
        bit  clash;
        rep.status      = STS_OK;
        rep.found_start = '0;
        rep.found_end   = '0;
        rep.found_room  = '0;
        case (cmd)
            CMD_INSERT: begin
                clash = 1'b0;
                for (idx = 0; idx < tbl_count; idx++) begin
                    // half-open intersection
                    if (s < tbl_end[idx] && e > tbl_start[idx])
                        clash = 1'b1;
                end
                if (s >= e || e > DAY_END) begin
                    rep.status = STS_INVALID;
                end else if (clash) begin
                    rep.status = STS_OVERLAP;
                end else if (tbl_count >= TABLE_DEPTH) begin
                    rep.status = STS_FULL;
                end else begin
                    pos = 0;
                    while (pos < tbl_count && tbl_start[pos] < s)
                        pos++;
                    for (idx = tbl_count; idx > pos; idx--) begin
                        tbl_start[idx] = tbl_start[idx-1];
                        tbl_end[idx]   = tbl_end[idx-1];
                        tbl_room[idx]  = tbl_room[idx-1];
                    end
                    tbl_start[pos] = s;
                    tbl_end[pos]   = e;
                    tbl_room[pos]  = r;
                    tbl_count++;
                end
            end
            CMD_REMOVE: begin
                pos = locate_start(s);
                if (pos < 0) begin
                    rep.status = STS_MISSING;
                end else begin
                    for (idx = pos; idx + 1 < tbl_count; idx++) begin
                        tbl_start[idx] = tbl_start[idx+1];
                        tbl_end[idx]   = tbl_end[idx+1];
                        tbl_room[idx]  = tbl_room[idx+1];
                    end
                    tbl_count--;
                end
            end
            CMD_FIND: begin
                pos = locate_start(s);
                if (pos < 0) begin
                    rep.status = STS_MISSING;
                end else begin
                    rep.found_start = tbl_start[pos];
                    rep.found_end   = tbl_end[pos];
                    rep.found_room  = tbl_room[pos];
                end
            end
            default: begin
                rep.status = STS_INVALID;
            end
        endcase
        rep.entry_total = tbl_count[TOTAL_W-1:0];
        if (tbl_count > peak_count)
            peak_count = tbl_count;
    endtask

    task automatic queue_booking(input t_cmd cmd, input int s, input int e, input int r,
                                 input bit drain = 1'b0);
        t_booking_req req;
        req.cmd          = cmd;
        req.slot_start   = s[TIME_W-1:0];
        req.slot_end     = e[TIME_W-1:0];
        req.room         = r[ROOM_W-1:0];
        req.drain_before = drain;
        pending_bookings.push_back(req);
        if (cmd == CMD_INSERT)
            key_pool.push_back(req.slot_start);
    endtask

    // mostly start keys of queued inserts, sometimes anything
    function automatic int pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 9) < 8)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom_range(0, 2047);
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("sorted_interval_reservation_table: mismatch");
            $finish;
        end
    end

    // driver: bursts of transfers separated by random gaps
    int burst_left = 1;
    int gap_left = 3;

    always @(posedge i_clk) begin : driver
        t_booking_reply rep;
        t_booking_req   req;
        bit             accepted;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            accepted = i_valid && o_ready;
            if (accepted) begin
                apply_booking(t_cmd'(i_cmd), i_start_time, i_end_time, i_room, rep);
                booking_replies.push_back(rep);
                status_tally[rep.status]++;
                items_taken <= items_taken + 1;
            end
            if (accepted || !i_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_bookings.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_bookings[0].drain_before &&
                             (i_valid || items_taken != results_seen)) begin
                    // hold off until every outstanding result is back
                    i_valid <= 1'b0;
                end else begin
                    req = pending_bookings.pop_front();
                    i_cmd        <= req.cmd;
                    i_start_time <= req.slot_start;
                    i_end_time   <= req.slot_end;
                    i_room       <= req.room;
                    i_valid      <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // monitor: checks each result transfer against the oldest prediction
    int  ready_hold = 0;
    bit  ready_level = 1'b1;

    always @(posedge i_clk) begin : monitor
        t_booking_reply want;
        int             mode;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (booking_replies.size() == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding, status %0d",
                                              o_status));
                end else begin
                    want = booking_replies.pop_front();
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, predicted %0d",
                                                  o_status, want.status));
                    if (o_found_start !== want.found_start)
                        report_mismatch($sformatf("found_start %0d, predicted %0d",
                                                  o_found_start, want.found_start));
                    if (o_found_end !== want.found_end)
                        report_mismatch($sformatf("found_end %0d, predicted %0d",
                                                  o_found_end, want.found_end));
                    if (o_found_room !== want.found_room)
                        report_mismatch($sformatf("found_room %0h, predicted %0h",
                                                  o_found_room, want.found_room));
                    if (o_entry_total !== want.entry_total)
                        report_mismatch($sformatf("entry_total %0d, predicted %0d",
                                                  o_entry_total, want.entry_total));
                end
            end
            // stall pattern rotates through three modes as the run goes on
            if (ready_hold == 0) begin
                mode = (cycle_count / 1000) % 3;
                case (mode)
                    0: begin
                        ready_level = 1'b1;
                        ready_hold = 50;
                    end
                    1: begin
                        ready_level = $urandom_range(0, 1);
                        ready_hold = 1;
                    end
                    default: begin
                        ready_level = !ready_level;
                        ready_hold = ready_level ? $urandom_range(1, 6) : $urandom_range(1, 30);
                    end
                endcase
            end
            ready_hold--;
            i_ready <= ready_level;
        end
    end

    initial begin : stimulus
        int slots [TABLE_DEPTH];
        int idx;
        int s;
        int roll;
        int k;

        // directed: empty table, validity edges, overlap edges, hits and misses
        queue_booking(CMD_FIND,   0, 0, 0);
        queue_booking(CMD_REMOVE, 5, 0, 0);
        queue_booking(CMD_INSERT, 100, 100, 16'h1234);
        queue_booking(CMD_INSERT, 200, 100, 16'h0001);
        queue_booking(CMD_INSERT, 0, 1537, 16'h0002);
        queue_booking(CMD_INSERT, 2047, 2047, 16'hFFFF);
        queue_booking(CMD_INSERT, 1472, 1536, 16'hFFFF);
        queue_booking(CMD_INSERT, 0, 64, 16'h0000);
        queue_booking(CMD_INSERT, 64, 128, 16'h8001);
        queue_booking(CMD_INSERT, 100, 110, 16'h0003);
        queue_booking(CMD_INSERT, 1400, 1500, 16'h0004);
        queue_booking(CMD_INSERT, 1000, 1010, 16'hA5A5);
        queue_booking(CMD_FIND,   64, 0, 0);
        queue_booking(CMD_FIND,   1472, 0, 0);
        queue_booking(CMD_FIND,   65, 0, 0);
        queue_booking(CMD_NONE,   $urandom_range(0, 2047), $urandom_range(0, 2047),
                      $urandom_range(0, 65535));
        queue_booking(CMD_REMOVE, 64, 0, 0);
        queue_booking(CMD_REMOVE, 64, 0, 0);
        queue_booking(CMD_FIND,   1000, 0, 0);
        queue_booking(CMD_INSERT, 63, 65, 16'h5A5A);
        queue_booking(CMD_REMOVE, 0, 0, 0);
        queue_booking(CMD_FIND,   0, 0, 0);
        queue_booking(CMD_REMOVE, 1472, 0, 0);
        queue_booking(CMD_REMOVE, 1000, 0, 0);

        // fill every grid slot in random order until the table is at capacity
        for (idx = 0; idx < TABLE_DEPTH; idx++)
            slots[idx] = idx;
        slots.shuffle();
        for (idx = 0; idx < TABLE_DEPTH; idx++) begin
            s = slots[idx] * SLOT_PITCH + $urandom_range(0, 3);
            queue_booking(CMD_INSERT, s, s + $urandom_range(1, 20), $urandom_range(0, 65535),
                          idx == 0);
        end
        // clean gaps at the top of six random slots: rejected as full
        for (idx = 0; idx < 6; idx++) begin
            k = $urandom_range(0, TABLE_DEPTH - 1);
            queue_booking(CMD_INSERT, k * SLOT_PITCH + 23, k * SLOT_PITCH + 24,
                          $urandom_range(0, 65535));
        end
        // overlap is checked before space
        queue_booking(CMD_INSERT, 0, 1536, $urandom_range(0, 65535));
        queue_booking(CMD_INSERT, 500, 700, $urandom_range(0, 65535));
        for (idx = 0; idx < 4; idx++)
            queue_booking(CMD_FIND, pick_key(), 0, 0);

        // mixed traffic: mostly well-formed bookings, some noise
        for (idx = 0; idx < 370; idx++) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                queue_booking(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 2047),
                              $urandom_range(0, 2047), $urandom_range(0, 65535),
                              idx % 120 == 60);
            end else if (roll < 52) begin
                if ($urandom_range(0, 1)) begin
                    s = $urandom_range(0, TABLE_DEPTH - 1) * SLOT_PITCH + $urandom_range(0, 3);
                    queue_booking(CMD_INSERT, s, s + $urandom_range(1, 20),
                                  $urandom_range(0, 65535), idx % 120 == 60);
                end else begin
                    s = $urandom_range(0, 1535);
                    queue_booking(CMD_INSERT, s, s + $urandom_range(1, 80),
                                  $urandom_range(0, 65535), idx % 120 == 60);
                end
            end else if (roll < 76) begin
                queue_booking(CMD_REMOVE, pick_key(), $urandom_range(0, 2047),
                              $urandom_range(0, 65535), idx % 120 == 60);
            end else begin
                queue_booking(CMD_FIND, pick_key(), $urandom_range(0, 2047),
                              $urandom_range(0, 65535), idx % 120 == 60);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bookings.size() != 0 || i_valid || items_taken != results_seen)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (booking_replies.size() != 0)
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      booking_replies.size()));

        $display("covered %0d commands and %0d results, table peaked at %0d of %0d entries",
                 items_taken, results_seen, peak_count, TABLE_DEPTH);
        $display("outcomes: ok %0d, invalid %0d, overlap %0d, full %0d, not found %0d",
                 status_tally[STS_OK], status_tally[STS_INVALID], status_tally[STS_OVERLAP],
                 status_tally[STS_FULL], status_tally[STS_MISSING]);
        if (error_count == 0) begin
            $display("sorted_interval_reservation_table: match");
        end else begin
            $display("%0d errors", error_count);
            $display("sorted_interval_reservation_table: mismatch");
        end
        $finish;
    end

endmodule
